// ===== rtl/wsir_pkg.sv =====
// ----------------------------------------------------------------------------
// wsir_pkg
// Shared types and constants of the wavetable sound and IRQ register block.
// ----------------------------------------------------------------------------
package wsir_pkg;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CPU   = 2'd2;
   localparam logic [1:0] OP_APU   = 2'd3;

   localparam logic [4:0] PAGE_SOUND = 5'h09; // 0x4800
   localparam logic [4:0] PAGE_IRQLO = 5'h0A; // 0x5000
   localparam logic [4:0] PAGE_IRQHI = 5'h0B; // 0x5800
   localparam logic [4:0] PAGE_PTR   = 5'h1F; // 0xF800

   localparam logic [19:0] FREQ_BASE = 20'hF0000;

   // divider request: dividend and divisor
   typedef struct packed {
      logic        start;
      logic [22:0] dividend;
      logic [17:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [22:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/wavetable_sound_irq_regs.sv =====
// ----------------------------------------------------------------------------
// wavetable_sound_irq_regs
// Bus-side sound RAM, eight wavetable channels and a 16-bit IRQ counter.
// ----------------------------------------------------------------------------
// Usage: each req_ word carries one bus event (write, read, CPU tick or
// APU tick). Exactly one rsp_ word answers it, carrying the read byte, the
// IRQ level and the eight channel samples after the event.
// Path from accept to rsp_valid: reads, IRQ writes, pointer writes and
// CPU ticks pass ST_RD, ST_EXEC and ST_DONE; a sound RAM write passes the
// same states and adds a channel write back when it lands on a channel
// register, and before that a bit-serial divide when it changes a channel
// frequency to a nonzero value. An APU tick walks the channel memory one
// channel at a time (read, wave fetch, write back).
// One word is in work at a time; req_ready is low until the answer has
// been taken. A stalled receiver holds rsp_ words and the block takes no
// new word until the held one is taken.
// State lives in three memories: sound RAM (128 x 8), wave nibbles
// (256 x 4) and a channel memory (8 entries). After reset a clearing pass
// zeroes the memories before req_ready rises.
module wavetable_sound_irq_regs #(
   parameter int NUM_CHANNELS = 8,
   parameter int RAM_BYTES    = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_open_bus,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_irq_line,
   output logic [3:0]  rsp_sample_ch0,
   output logic [3:0]  rsp_sample_ch1,
   output logic [3:0]  rsp_sample_ch2,
   output logic [3:0]  rsp_sample_ch3,
   output logic [3:0]  rsp_sample_ch4,
   output logic [3:0]  rsp_sample_ch5,
   output logic [3:0]  rsp_sample_ch6,
   output logic [3:0]  rsp_sample_ch7
);
   import wsir_pkg::*;

   localparam int PW = $clog2(RAM_BYTES);

   // channel record: freq, reload, countdown, length, step, start, volume
   typedef struct packed {
      logic [17:0] freq;
      logic [22:0] reload;
      logic [22:0] count;
      logic [5:0]  len;
      logic [5:0]  step;
      logic [7:0]  wstart;
      logic [3:0]  vol;
      logic        active;
   } chan_type;

   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b0000000001,
      ST_IDLE   = 10'b0000000010,
      ST_RD     = 10'b0000000100,
      ST_EXEC   = 10'b0000001000,
      ST_DIV    = 10'b0000010000,
      ST_APURD  = 10'b0000100000,
      ST_APUEX  = 10'b0001000000,
      ST_APUWB  = 10'b0010000000,
      ST_DONE   = 10'b0100000000,
      ST_OUT    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // memories
   logic [7:0] sram [RAM_BYTES];
   logic [3:0] wave [256];
   chan_type   cmem [8];

   logic [7:0] sram_q;
   logic [3:0] wave_q;
   chan_type   cmem_q;

   logic       sram_we;  logic [PW-1:0] sram_wa; logic [7:0] sram_wd;
   logic       wave_we0; logic [7:0] wave_wa0; logic [3:0] wave_wd0;
   logic       wave_we1; logic [7:0] wave_wa1; logic [3:0] wave_wd1;
   logic [7:0] wave_ra;
   logic       cmem_we;  logic [2:0] cmem_wa; chan_type cmem_wd;
   logic [2:0] cmem_ra;

   // request latch
   logic [1:0]  op_ff;
   logic [15:0] addr_ff;
   logic [7:0]  wd_ff, ob_ff;

   // scalar state
   logic [6:0]  ptr_ff, ptr_in;
   logic        ainc_ff, ainc_in;
   logic [2:0]  first_ff, first_in;
   logic        ctl_ff, ctl_in;
   logic [15:0] irqc_ff, irqc_in;
   logic        dly_ff, dly_in;
   logic        irq_ff, irq_in;
   logic [3:0]  out_ff [8];
   logic [3:0]  outv_in;
   logic        outw;
   logic [7:0]  clr_ff, clr_in;
   logic [2:0]  ch_ff, ch_in;
   chan_type    work_ff, work_in;
   logic [7:0]  rd_ff, rd_in;
   logic        rsp_valid_ff;

   div_req_type dreq;
   div_rsp_type drsp;

   wsir_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // memory ports
   always_ff @(posedge clock) begin
      if (sram_we) sram[sram_wa] <= sram_wd;
      sram_q <= sram[ptr_ff[PW-1:0]];
   end
   always_ff @(posedge clock) begin
      if (wave_we0) wave[wave_wa0] <= wave_wd0;
      if (wave_we1) wave[wave_wa1] <= wave_wd1;
      wave_q <= wave[wave_ra];
   end
   always_ff @(posedge clock) begin
      if (cmem_we) cmem[cmem_wa] <= cmem_wd;
      cmem_q <= cmem[cmem_ra];
   end

   // decoded request
   logic [4:0]  page;
   logic [2:0]  cidx;
   logic        chan_hit;
   logic [3:0]  nlo, nhi;
   logic [17:0] fnew;
   logic [5:0]  lnew;
   logic [3:0]  nch;
   logic        en_c;
   logic [2:0]  first_eff;

   always_comb begin
      page     = addr_ff[15:11];
      cidx     = ptr_ff[5:3];
      chan_hit = ptr_ff[6] && ({1'b0, cidx} < 4'(NUM_CHANNELS));
      nlo      = (wd_ff[3:0] < 4'd8) ? 4'd8 : wd_ff[3:0];
      nhi      = (wd_ff[7:4] < 4'd8) ? 4'd8 : wd_ff[7:4];
      lnew     = {3'd0, 3'd0} + {(4'd8 - {1'b0, wd_ff[4:2]}), 2'b00};
      case (ptr_ff[2:0])
         3'd0:    fnew = {cmem_q.freq[17:8], wd_ff};
         3'd2:    fnew = {cmem_q.freq[17:16], wd_ff, cmem_q.freq[7:0]};
         3'd4:    fnew = {wd_ff[1:0], cmem_q.freq[15:0]};
         default: fnew = cmem_q.freq;
      endcase
      first_eff = (ptr_ff == 7'h7F) ? 3'd7 - wd_ff[6:4] : first_ff;
      // channels stay disabled until the control byte has been written once
      en_c      = ((ptr_ff == 7'h7F) || ctl_ff) && (cidx >= first_eff);
      nch       = 4'd8 - {1'b0, first_ff};
   end

   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff; ainc_in = ainc_ff; first_in = first_ff; ctl_in = ctl_ff;
      irqc_in = irqc_ff; dly_in = dly_ff; irq_in = irq_ff;
      clr_in = clr_ff; ch_in = ch_ff; work_in = work_ff; rd_in = rd_ff;
      outw = 1'b0; outv_in = wave_q;
      sram_we = 1'b0; sram_wa = ptr_ff[PW-1:0]; sram_wd = wd_ff;
      wave_we0 = 1'b0; wave_wa0 = {ptr_ff, 1'b0}; wave_wd0 = nlo;
      wave_we1 = 1'b0; wave_wa1 = {ptr_ff, 1'b1}; wave_wd1 = nhi;
      wave_ra = work_ff.wstart + {2'b00, work_ff.step};
      cmem_we = 1'b0; cmem_wa = ch_ff; cmem_wd = work_ff; cmem_ra = ch_ff;
      dreq = '0;
      dreq.dividend = {3'd0, FREQ_BASE} * {19'd0, nch};
      dreq.divisor  = work_ff.freq;
      case (state_ff)
         ST_CLEAR: begin
            // zero one entry of each memory per cycle
            sram_we = 1'b1; sram_wa = clr_ff[PW-1:0]; sram_wd = '0;
            wave_we0 = 1'b1; wave_wa0 = clr_ff; wave_wd0 = '0;
            cmem_we = 1'b1; cmem_wa = clr_ff[2:0]; cmem_wd = '0;
            clr_in = clr_ff + 8'd1;
            if (clr_ff == 8'hFF) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_RD;
         end
         ST_RD: begin
            // memories read at the pointer / channel address this cycle
            cmem_ra = cidx;
            rd_in = 8'd0;
            ch_in = first_ff;
            if (op_ff == OP_APU) state_in = ST_APURD;
            else state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (op_ff)
               OP_WRITE: begin
                  if (addr_ff >= 16'h4800) begin
                     case (page)
                        PAGE_SOUND: begin
                           sram_we = 1'b1; wave_we0 = 1'b1; wave_we1 = 1'b1;
                           if (ptr_ff == 7'h7F) begin
                              first_in = first_eff; ctl_in = 1'b1;
                           end
                           ptr_in = ptr_ff + {6'd0, ainc_ff};
                           if (chan_hit) begin
                              work_in = cmem_q;
                              ch_in = cidx;
                              if (ptr_ff[2:0] == 3'd4 && cmem_q.len != lnew) begin
                                 work_in.len = lnew; work_in.step = 6'd0;
                              end
                              if (ptr_ff[2:0] == 3'd6) work_in.wstart = wd_ff;
                              if (ptr_ff[2:0] == 3'd7) work_in.vol = wd_ff[3:0];
                              work_in.freq = fnew;
                              work_in.active = en_c && fnew != '0 &&
                                               work_in.vol != '0;
                              if (fnew != cmem_q.freq && fnew != '0)
                                 state_in = ST_DIV;
                              else
                                 state_in = ST_APUWB;
                           end
                        end
                        PAGE_IRQLO: begin
                           irqc_in = {irqc_ff[15:8], wd_ff}; irq_in = 1'b0;
                        end
                        PAGE_IRQHI: begin
                           irqc_in = {wd_ff, irqc_ff[7:0]}; irq_in = 1'b0;
                        end
                        PAGE_PTR: begin
                           ainc_in = wd_ff[7]; ptr_in = wd_ff[6:0];
                        end
                        default: ;
                     endcase
                  end
               end
               OP_READ: begin
                  rd_in = ob_ff;
                  if (addr_ff >= 16'h4800 && addr_ff < 16'h6000) begin
                     case (page)
                        PAGE_SOUND: begin
                           rd_in = sram_q; ptr_in = ptr_ff + {6'd0, ainc_ff};
                        end
                        PAGE_IRQLO: rd_in = irqc_ff[7:0];
                        PAGE_IRQHI: rd_in = irqc_ff[15:8];
                        default: ;
                     endcase
                  end
               end
               default: begin
                  if (dly_ff) begin dly_in = 1'b0; irq_in = 1'b1; end
                  if (irqc_ff[15] && irqc_ff != 16'hFFFF) begin
                     irqc_in = irqc_ff + 16'd1;
                     if (irqc_ff == 16'hFFFE) dly_in = 1'b1;
                  end
               end
            endcase
            if (state_in == ST_DIV) begin
               dreq.start = 1'b1;
               dreq.divisor = fnew;
            end
         end
         ST_DIV: begin
            dreq.divisor = work_ff.freq;
            if (drsp.done) begin
               work_in.reload = drsp.quotient;
               work_in.count  = drsp.quotient;
               state_in = ST_APUWB;
            end
         end
         ST_APURD: begin
            // channel entry ch_ff is being read
            if ({1'b0, ch_ff} >= 4'(NUM_CHANNELS)) state_in = ST_DONE;
            else state_in = ST_APUEX;
         end
         ST_APUEX: begin
            // fetch the wave nibble of this channel for the write back
            wave_ra = cmem_q.wstart + {2'b00, cmem_q.step};
            work_in = cmem_q;
            state_in = ST_APUWB;
            if (cmem_q.active) begin
               work_in.count = cmem_q.count - 23'd1;
            end
         end
         ST_APUWB: begin
            // wave_q holds the nibble at start+step of work_ff
            if (op_ff == OP_APU && work_ff.active && work_ff.count == '0) begin
               outw = 1'b1;
               cmem_wd.count = work_ff.reload;
               cmem_wd.step = (work_ff.step + 6'd1 == work_ff.len) ? 6'd0
                                                                  : work_ff.step + 6'd1;
            end
            cmem_we = 1'b1;
            if (op_ff == OP_APU && ch_ff != 3'd7) begin
               ch_in = ch_ff + 3'd1;
               cmem_ra = ch_ff + 3'd1;
               state_in = ST_APURD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0;
         ptr_ff <= '0; ainc_ff <= 1'b1; first_ff <= 3'd7; ctl_ff <= 1'b0;
         irqc_ff <= '0; dly_ff <= 1'b0; irq_ff <= 1'b0;
         for (int i = 0; i < 8; i++) out_ff[i] <= '0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in;
         ptr_ff <= ptr_in; ainc_ff <= ainc_in; first_ff <= first_in; ctl_ff <= ctl_in;
         irqc_ff <= irqc_in; dly_ff <= dly_in; irq_ff <= irq_in;
         if (outw) out_ff[ch_ff] <= outv_in;
      end
      ch_ff <= ch_in; work_ff <= work_in; rd_ff <= rd_in;
      if (state_ff == ST_IDLE && req_valid) begin
         op_ff <= req_operation; addr_ff <= req_address;
         wd_ff <= req_write_data; ob_ff <= req_open_bus;
      end
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid_ff = (state_ff == ST_OUT);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_read_data  = rd_ff;
   assign rsp_irq_line   = irq_ff;
   assign rsp_sample_ch0 = out_ff[0];
   assign rsp_sample_ch1 = out_ff[1];
   assign rsp_sample_ch2 = out_ff[2];
   assign rsp_sample_ch3 = out_ff[3];
   assign rsp_sample_ch4 = out_ff[4];
   assign rsp_sample_ch5 = out_ff[5];
   assign rsp_sample_ch6 = out_ff[6];
   assign rsp_sample_ch7 = out_ff[7];

   // a word is taken only when no answer is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid) else $error("overlap");
   // the IRQ is raised only by a CPU tick after the delay flag
   a_irq_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(irq_ff) |-> $past(dly_ff)) else $error("irq rise");
   // the delay flag is only set when the counter has reached its top
   a_dly: assert property (@(posedge clock) disable iff (reset)
      $rose(dly_ff) |-> irqc_ff == 16'hFFFF) else $error("delay flag");
endmodule

// ===== rtl/wsir_div.sv =====
// ----------------------------------------------------------------------------
// wsir_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wsir_div (
   input  logic                 clock,
   input  logic                 reset,
   input  wsir_pkg::div_req_type req,
   output wsir_pkg::div_rsp_type rsp
);
   import wsir_pkg::*;

   logic [22:0] quo_ff, quo_in;
   logic [18:0] rem_ff, rem_in;
   logic [17:0] dsr_ff, dsr_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [18:0] trial;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dsr_in = dsr_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[17:0], quo_ff[22]};
      if (req.start) begin
         quo_in = req.dividend; rem_in = '0; dsr_in = req.divisor;
         cnt_in = 5'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[21:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[21:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd22) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule
